>>> rtl/battery_energy_tracker_hysteresis_macros.svh
// ----------------------------------------------------------------------------
// Battery energy tracker assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef BATTERY_ENERGY_TRACKER_HYSTERESIS_MACROS_SVH
`define BATTERY_ENERGY_TRACKER_HYSTERESIS_MACROS_SVH

// check a consequence in the same cycle
`define BET_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a consequence in the following cycle
`define BET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery energy tracker package
// Field widths, register indexes, event codes, reset values and commands.
// ----------------------------------------------------------------------------
package bet_pkg;

	localparam int ENERGY_BITS_DEF = 56;
	localparam int CUR_W = 20;
	localparam int MV_W = 13;
	localparam int EL_W = 24;
	localparam int FRAC_W = 16;
	localparam int EVENT_W = 2;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_INIT_ENERGY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_MV = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_FRAC = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_FRAC = 3'd3;

	localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
	localparam logic [EVENT_W-1:0] EV_CHANGED = 2'd1;
	localparam logic [EVENT_W-1:0] EV_DRAINED = 2'd2;
	localparam logic [EVENT_W-1:0] EV_RECHARGED = 2'd3;

	localparam logic [63:0] INIT_ENERGY_RST = 64'd10000000000000000;
	localparam logic [MV_W-1:0] SUPPLY_MV_RST = 13'd3000;
	localparam logic [FRAC_W-1:0] LOW_FRAC_RST = 16'd6554;
	localparam logic [FRAC_W-1:0] HIGH_FRAC_RST = 16'd9830;

	typedef struct packed {
		logic cfg_wr;
		logic load;
		logic mul1;
		logic mul2;
		logic sub;
		logic cmp;
	} bet_cmd_t;

endpackage

>>> rtl/bet_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery energy tracker controller
// Sequences one word through multiply, subtract and compare steps and owns
// the handshakes of the input, output and configuration channels.
// ----------------------------------------------------------------------------
module bet_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	output bet_pkg::bet_cmd_t cmd
);
	import bet_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_MUL2 = 3'd2;
	localparam logic [2:0] ST_SUB  = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       cmp_go;

	// hold input words while a word is in work or a configuration write is pending
	assign in_stall = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmp_go = (state_q == ST_CMP) && (!out_valid_q || !out_stall);

	always_comb begin
		cmd.cfg_wr = cfg_valid && (state_q == ST_IDLE);
		cmd.load = in_valid && !cfg_valid && (state_q == ST_IDLE);
		cmd.mul1 = (state_q == ST_MUL1);
		cmd.mul2 = (state_q == ST_MUL2);
		cmd.sub = (state_q == ST_SUB);
		cmd.cmp = cmp_go;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (cmd.load) state_nxt = ST_MUL1;
			ST_MUL1: state_nxt = ST_MUL2;
			ST_MUL2: state_nxt = ST_SUB;
			ST_SUB:  state_nxt = ST_CMP;
			ST_CMP:  if (cmp_go) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// hold the word until taken, load a fresh one on compare
			if (cmp_go) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/bet_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery energy tracker datapath
// Configuration registers, energy state, drain and threshold products,
// clamped subtract, hysteresis compare and the output word register.
// ----------------------------------------------------------------------------
module bet_dp #(
	parameter int ENERGY_BITS = bet_pkg::ENERGY_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bet_pkg::bet_cmd_t              cmd,
	input  logic [bet_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ENERGY_BITS-1:0]         cfg_data,
	input  logic                           mode,
	input  logic [bet_pkg::CUR_W-1:0]      current_ua,
	input  logic [bet_pkg::EL_W-1:0]       elapsed_us,
	input  logic [ENERGY_BITS-1:0]         fixed_energy_fj,
	output logic [ENERGY_BITS-1:0]         remaining_fj,
	output logic                           depleted,
	output logic [bet_pkg::EVENT_W-1:0]    event_res,
	output logic                           underflow
);
	import bet_pkg::*;

	localparam int CM_W = CUR_W + MV_W;
	localparam int MUL_W = CM_W + EL_W;
	localparam int DRAIN_W = (ENERGY_BITS > MUL_W) ? ENERGY_BITS : MUL_W;
	localparam int THR_A_W = FRAC_W + 32;
	localparam int HI_W = (ENERGY_BITS > 32) ? ENERGY_BITS - 32 : 1;
	localparam int THR_B_W = FRAC_W + HI_W;
	localparam int THR_W = ENERGY_BITS + FRAC_W;
	localparam logic [ENERGY_BITS-1:0] INIT_RST = ENERGY_BITS'(INIT_ENERGY_RST);

	logic [ENERGY_BITS-1:0] init_q;
	logic [MV_W-1:0]        mv_q;
	logic [FRAC_W-1:0]      low_frac_q;
	logic [FRAC_W-1:0]      high_frac_q;
	logic [ENERGY_BITS-1:0] rem_q;
	logic                   dep_q;

	logic                   mode_s1;
	logic [CUR_W-1:0]       cur_s1;
	logic [EL_W-1:0]        el_s1;
	logic [ENERGY_BITS-1:0] fixed_s1;
	logic [FRAC_W-1:0]      frac_s1;
	logic [CM_W-1:0]        cm_s2;
	logic [THR_A_W-1:0]     thr_a_s2;
	logic [DRAIN_W-1:0]     drain_s3;
	logic [THR_A_W-1:0]     thr_a_s3;
	logic [THR_B_W-1:0]     thr_b_s3;
	logic [ENERGY_BITS-1:0] new_s4;
	logic                   uf_s4;
	logic [THR_W-1:0]       thr_s4;

	logic [ENERGY_BITS-1:0] rem_out_q;
	logic                   dep_out_q;
	logic [EVENT_W-1:0]     ev_out_q;
	logic                   uf_out_q;

	logic [HI_W-1:0]        init_hi;
	logic [MUL_W-1:0]       drain_mul;
	logic [DRAIN_W:0]       diff;
	logic [THR_W-1:0]       lhs;
	logic                   at_or_below;
	logic                   dep_nxt;
	logic [EVENT_W-1:0]     ev_nxt;

	assign init_hi = HI_W'(init_q >> 32);
	assign drain_mul = MUL_W'(cm_s2) * MUL_W'(el_s1);
	assign diff = (DRAIN_W + 1)'(rem_q) - (DRAIN_W + 1)'(drain_s3);
	assign lhs = {new_s4, {FRAC_W{1'b0}}};
	assign at_or_below = (lhs <= thr_s4);

	always_comb begin
		dep_nxt = dep_q;
		ev_nxt = EV_NONE;
		if (!dep_q && at_or_below) begin
			dep_nxt = 1'b1;
			ev_nxt = EV_DRAINED;
		end else if (!mode_s1 && dep_q && !at_or_below) begin
			dep_nxt = 1'b0;
			ev_nxt = EV_RECHARGED;
		end else if (new_s4 != rem_q) begin
			ev_nxt = EV_CHANGED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= INIT_RST;
			mv_q <= SUPPLY_MV_RST;
			low_frac_q <= LOW_FRAC_RST;
			high_frac_q <= HIGH_FRAC_RST;
			rem_q <= INIT_RST;
			dep_q <= 1'b0;
		end else begin
			if (cmd.cfg_wr) begin
				unique case (cfg_index)
					REG_INIT_ENERGY: begin
						init_q <= cfg_data;
						rem_q <= cfg_data;
					end
					REG_SUPPLY_MV: mv_q <= cfg_data[MV_W-1:0];
					REG_LOW_FRAC:  low_frac_q <= cfg_data[FRAC_W-1:0];
					REG_HIGH_FRAC: high_frac_q <= cfg_data[FRAC_W-1:0];
					default: ;
				endcase
			end
			if (cmd.cmp) begin
				rem_q <= new_s4;
				dep_q <= dep_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_s1 <= mode;
			cur_s1 <= current_ua;
			el_s1 <= elapsed_us;
			fixed_s1 <= fixed_energy_fj;
			// pick the threshold that the current flag state can cross
			frac_s1 <= dep_q ? high_frac_q : low_frac_q;
		end
		if (cmd.mul1) begin
			cm_s2 <= CM_W'(cur_s1) * CM_W'(mv_q);
			thr_a_s2 <= THR_A_W'(frac_s1) * THR_A_W'(init_q[31:0]);
		end
		if (cmd.mul2) begin
			drain_s3 <= mode_s1 ? DRAIN_W'(fixed_s1) : DRAIN_W'(drain_mul);
			thr_a_s3 <= thr_a_s2;
			thr_b_s3 <= THR_B_W'(frac_s1) * THR_B_W'(init_hi);
		end
		if (cmd.sub) begin
			// clamp at zero on borrow
			new_s4 <= diff[DRAIN_W] ? '0 : diff[ENERGY_BITS-1:0];
			uf_s4 <= !mode_s1 && diff[DRAIN_W];
			thr_s4 <= (THR_W'(thr_b_s3) << 32) + THR_W'(thr_a_s3);
		end
		if (cmd.cmp) begin
			rem_out_q <= new_s4;
			dep_out_q <= dep_nxt;
			ev_out_q <= ev_nxt;
			uf_out_q <= uf_s4;
		end
	end

	assign remaining_fj = rem_out_q;
	assign depleted = dep_out_q;
	assign event_res = ev_out_q;
	assign underflow = uf_out_q;

endmodule

>>> rtl/battery_energy_tracker_hysteresis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery energy tracker with hysteresis
// Femtojoule energy gauge with a depleted flag and drain/recharge events.
// ----------------------------------------------------------------------------
// After its input word is accepted, a word passes through the chained current
// x voltage x time multiply in two steps (which also form the threshold
// product in two partial products), then the clamped subtract and then the
// threshold compare, which registers the result word. One word is in work at
// a time and the next can be accepted in the cycle after the compare; a
// result that waits at the output holds the next word at its compare step.
// Reset loads the remaining energy with the initial-energy reset value, and a
// write of the initial-energy register reloads it. Configuration is taken
// while no word is in work and wins over an input word offered in the same
// cycle.
`include "battery_energy_tracker_hysteresis_macros.svh"

module battery_energy_tracker_hysteresis #(
	parameter int ENERGY_BITS = bet_pkg::ENERGY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [bet_pkg::CUR_W-1:0]     current_ua,
	input  logic [bet_pkg::EL_W-1:0]      elapsed_us,
	input  logic [ENERGY_BITS-1:0]        fixed_energy_fj,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ENERGY_BITS-1:0]        remaining_fj,
	output logic                          depleted,
	output logic [bet_pkg::EVENT_W-1:0]   event_res,
	output logic                          underflow,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bet_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ENERGY_BITS-1:0]        cfg_data
);
	import bet_pkg::*;

	bet_cmd_t cmd;

	bet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	bet_dp #(
		.ENERGY_BITS (ENERGY_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mode            (mode),
		.current_ua      (current_ua),
		.elapsed_us      (elapsed_us),
		.fixed_energy_fj (fixed_energy_fj),
		.remaining_fj    (remaining_fj),
		.depleted        (depleted),
		.event_res       (event_res),
		.underflow       (underflow)
	);

	`BET_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "accepted word did not start work")
	`BET_ASSERT_NEXT(a_result_after_cmp, clk, arst_n, cmd.cmp, out_valid, "compare step produced no result word")
	`BET_ASSERT_SAME(a_one_step, clk, arst_n, 1'b1, $onehot0({cmd.load, cmd.mul1, cmd.mul2, cmd.sub, cmd.cmp}), "more than one datapath step at once")

endmodule

>>> sim/battery_energy_tracker_hysteresis_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery energy tracker testbench
// Drives drain and fixed-consumption words through the gauge under random
// gaps and output stalls, reprograms supply, thresholds and initial energy
// between phases, and checks every result word against an in-bench gauge.
// ----------------------------------------------------------------------------
module battery_energy_tracker_hysteresis_tb;

	import bet_pkg::*;

	localparam int EB = ENERGY_BITS_DEF;
	localparam logic [EB-1:0] ENERGY_MAX = {EB{1'b1}};

	typedef struct {
		bit [EB-1:0]      rem;
		bit               dep;
		bit [EVENT_W-1:0] ev;
		bit               uf;
	} gauge_word_t;

	class gauge_scoreboard;
		bit [EB-1:0]     init_energy;
		bit [MV_W-1:0]   supply_mv;
		bit [FRAC_W-1:0] low_frac;
		bit [FRAC_W-1:0] high_frac;
		bit [EB-1:0]     remaining;
		bit              depleted_flag;
		gauge_word_t     expected_words[$];
		int              failures;

		function new();
			init_energy = INIT_ENERGY_RST[EB-1:0];
			supply_mv = SUPPLY_MV_RST;
			low_frac = LOW_FRAC_RST;
			high_frac = HIGH_FRAC_RST;
			remaining = init_energy;
			depleted_flag = 1'b0;
			failures = 0;
		endfunction

		function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [EB-1:0] data);
			case (idx)
				REG_INIT_ENERGY: begin
					init_energy = data;
					remaining = data;
				end
				REG_SUPPLY_MV: supply_mv = data[MV_W-1:0];
				REG_LOW_FRAC: low_frac = data[FRAC_W-1:0];
				REG_HIGH_FRAC: high_frac = data[FRAC_W-1:0];
				default: ;
			endcase
		endfunction

		// e * 2^16 against frac * initial, full precision
		function int cmp_threshold(bit [EB-1:0] e, bit [FRAC_W-1:0] frac);
			bit [EB+FRAC_W-1:0] lhs;
			bit [EB+FRAC_W-1:0] rhs;
			lhs = {e, {FRAC_W{1'b0}}};
			rhs = (EB+FRAC_W)'(frac) * (EB+FRAC_W)'(init_energy);
			if (lhs < rhs)
				return -1;
			if (lhs > rhs)
				return 1;
			return 0;
		endfunction

		function void accept_item(bit m, bit [CUR_W-1:0] cur, bit [EL_W-1:0] el,
				bit [EB-1:0] fx);
			bit [63:0]   drain;
			bit [EB-1:0] prev;
			gauge_word_t w;
			prev = remaining;
			w.uf = 1'b0;
			w.ev = EV_NONE;
			if (!m) begin
				drain = 64'(cur) * 64'(supply_mv) * 64'(el);
				if (drain > 64'(prev)) begin
					remaining = '0;
					w.uf = 1'b1;
				end else begin
					remaining = prev - drain[EB-1:0];
				end
			end else begin
				remaining = (fx >= prev) ? '0 : prev - fx;
			end
			if (!depleted_flag && cmp_threshold(remaining, low_frac) <= 0) begin
				depleted_flag = 1'b1;
				w.ev = EV_DRAINED;
			end else if (!m && depleted_flag && cmp_threshold(remaining, high_frac) > 0) begin
				depleted_flag = 1'b0;
				w.ev = EV_RECHARGED;
			end else if (remaining != prev) begin
				w.ev = EV_CHANGED;
			end
			w.rem = remaining;
			w.dep = depleted_flag;
			expected_words.push_back(w);
		endfunction

		function void check_word(bit [EB-1:0] rem, bit dep, bit [EVENT_W-1:0] ev, bit uf);
			gauge_word_t w;
			if (expected_words.size() == 0) begin
				if (failures < 10)
					$display("ERROR: result word with nothing expected: rem=%0d dep=%0b ev=%0d uf=%0b",
						rem, dep, ev, uf);
				failures++;
				return;
			end
			w = expected_words.pop_front();
			if (w.rem !== rem || w.dep !== dep || w.ev !== ev || w.uf !== uf) begin
				if (failures < 10) begin
					$display("ERROR: expected rem=%0d dep=%0b ev=%0d uf=%0b", w.rem, w.dep, w.ev, w.uf);
					$display("       actual   rem=%0d dep=%0b ev=%0d uf=%0b", rem, dep, ev, uf);
				end
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic mode;
	logic [CUR_W-1:0] current_ua;
	logic [EL_W-1:0] elapsed_us;
	logic [EB-1:0] fixed_energy_fj;
	logic out_valid;
	logic out_stall;
	logic [EB-1:0] remaining_fj;
	logic depleted;
	logic [EVENT_W-1:0] event_res;
	logic underflow;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [EB-1:0] cfg_data;

	gauge_scoreboard sb = new();
	bit calm = 1'b0;

	battery_energy_tracker_hysteresis DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.current_ua(current_ua),
		.elapsed_us(elapsed_us),
		.fixed_energy_fj(fixed_energy_fj),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.remaining_fj(remaining_fj),
		.depleted(depleted),
		.event_res(event_res),
		.underflow(underflow),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit [EB-1:0] rand_energy();
		bit [63:0] v;
		v = {$urandom, $urandom};
		if ($urandom_range(0, 1))
			return v[EB-1:0];
		return v[EB-1:0] >> $urandom_range(0, EB-1);
	endfunction

	function automatic bit [EB-1:0] pick_energy();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ENERGY_MAX;
			2: return EB'($urandom_range(0, 1000));
			default: return rand_energy() | (EB'(1) << $urandom_range(36, EB-1));
		endcase
	endfunction

	function automatic bit [FRAC_W-1:0] pick_frac();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return {FRAC_W{1'b1}};
			default: return FRAC_W'($urandom);
		endcase
	endfunction

	function automatic bit [MV_W-1:0] pick_mv();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return {MV_W{1'b1}};
			default: return MV_W'($urandom);
		endcase
	endfunction

	// upper bits above a narrow register are junk half the time
	function automatic bit [EB-1:0] pad_junk(bit [EB-1:0] v, int w);
		bit [EB-1:0] junk;
		junk = rand_energy();
		if ($urandom_range(0, 1))
			return v;
		return (junk << w) | v;
	endfunction

	always @(posedge clk) begin
		int hold_cnt;
		bit stall_now;
		if (arst_n && out_valid && !out_stall)
			sb.check_word(remaining_fj, depleted, event_res, underflow);
		if (hold_cnt == 0) begin
			stall_now = !stall_now;
			hold_cnt = stall_now ? rand_gap() : $urandom_range(1, 12);
		end else begin
			hold_cnt--;
		end
		out_stall <= calm ? 1'b0 : stall_now;
	end

	task automatic send_word(input bit m, input bit [CUR_W-1:0] cur,
			input bit [EL_W-1:0] el, input bit [EB-1:0] fx);
		int gap;
		gap = calm ? 0 : rand_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		current_ua <= cur;
		elapsed_us <= el;
		fixed_energy_fj <= fx;
		do @(posedge clk); while (in_stall);
		sb.accept_item(m, cur, el, fx);
	endtask

	// drop valid, drain every expected word, then let the pipe settle
	task automatic quiesce();
		in_valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input bit [CFG_IDX_W-1:0] idx, input bit [EB-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drain sized against the current charge so sequences reach the thresholds
	task automatic send_shaped();
		bit m;
		bit [CUR_W-1:0] cur;
		bit [EL_W-1:0] el;
		bit [EB-1:0] fx;
		bit [63:0] want;
		bit [63:0] per;
		if ($urandom_range(0, 99) < 15) begin
			m = 1'($urandom);
			cur = CUR_W'($urandom);
			el = EL_W'($urandom);
			fx = rand_energy();
		end else begin
			m = 1'($urandom_range(0, 1));
			want = 64'(sb.remaining) / $urandom_range(3, 40);
			if ($urandom_range(0, 19) == 0)
				want = 64'(sb.remaining);
			cur = CUR_W'($urandom_range(1, (1 << CUR_W) - 1) >> $urandom_range(0, CUR_W-1));
			if (cur == 0)
				cur = 1;
			per = 64'(cur) * 64'(sb.supply_mv);
			if (per == 0)
				el = EL_W'($urandom);
			else if (want / per > 64'({EL_W{1'b1}}))
				el = {EL_W{1'b1}};
			else
				el = EL_W'(want / per);
			fx = want[EB-1:0];
		end
		send_word(m, cur, el, fx);
	endtask

	initial begin
		int count;
		int n;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= 1'b0;
		current_ua <= '0;
		elapsed_us <= '0;
		fixed_energy_fj <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, zero and extreme operands
		send_word(1'b0, '0, '0, ENERGY_MAX);
		send_word(1'b1, {CUR_W{1'b1}}, {EL_W{1'b1}}, '0);
		send_word(1'b0, {CUR_W{1'b1}}, '0, '0);
		send_word(1'b0, '0, {EL_W{1'b1}}, '0);
		send_word(1'b0, 20'd1000, 24'd1000, '0);
		send_word(1'b1, '0, '0, 56'd12345);

		// exact threshold hit, recharge in mode 0, none in mode 1
		quiesce();
		write_cfg(REG_INIT_ENERGY, EB'(1) << 40);
		write_cfg(REG_LOW_FRAC, EB'(16'h8000));
		send_word(1'b1, '0, '0, (EB'(1) << 39) - 1);
		send_word(1'b1, '0, '0, EB'(1));
		send_word(1'b0, '0, '0, '0);
		send_word(1'b1, '0, '0, '0);
		send_word(1'b1, '0, '0, '0);

		// drain equal to charge, drain past charge, fixed clamp
		quiesce();
		write_cfg(REG_INIT_ENERGY, EB'(64'd3000 * 64'd5000 * 64'd7000));
		send_word(1'b0, 20'd5000, 24'd7000, '0);
		send_word(1'b0, 20'd1, 24'd1, '0);
		send_word(1'b1, '0, '0, ENERGY_MAX);

		// extreme registers
		quiesce();
		write_cfg(REG_SUPPLY_MV, EB'({MV_W{1'b1}}));
		write_cfg(REG_INIT_ENERGY, ENERGY_MAX);
		write_cfg(REG_LOW_FRAC, '0);
		write_cfg(REG_HIGH_FRAC, EB'({FRAC_W{1'b1}}));
		send_word(1'b0, {CUR_W{1'b1}}, {EL_W{1'b1}}, '0);
		send_word(1'b1, '0, '0, '0);
		quiesce();
		write_cfg(REG_INIT_ENERGY, ENERGY_MAX);
		send_word(1'b0, '0, '0, '0);
		send_word(1'b1, '0, '0, ENERGY_MAX);
		quiesce();
		write_cfg(REG_LOW_FRAC, EB'({FRAC_W{1'b1}}));
		write_cfg(REG_HIGH_FRAC, '0);
		write_cfg(3'd5, ENERGY_MAX);
		write_cfg(REG_INIT_ENERGY, EB'(100));
		send_word(1'b0, '0, '0, '0);
		send_word(1'b1, '0, '0, '0);

		for (int ph = 0; ph < 10; ph++) begin
			quiesce();
			calm = ($urandom_range(0, 3) == 0);
			write_cfg(REG_SUPPLY_MV, pad_junk(EB'(pick_mv()), MV_W));
			write_cfg(REG_LOW_FRAC, pad_junk(EB'(pick_frac()), FRAC_W));
			write_cfg(REG_HIGH_FRAC, pad_junk(EB'(pick_frac()), FRAC_W));
			if ($urandom_range(0, 2) == 0)
				write_cfg(CFG_IDX_W'($urandom_range(4, 7)), rand_energy());
			write_cfg(REG_INIT_ENERGY, pick_energy());
			count = 0;
			while (count < 110) begin
				n = $urandom_range(5, 40);
				if (n > 110 - count)
					n = 110 - count;
				for (int k = 0; k < n; k++)
					send_shaped();
				count += n;
				quiesce();
				if ($urandom_range(0, 3) == 0)
					write_cfg($urandom_range(0, 1) ? REG_LOW_FRAC : REG_HIGH_FRAC,
						EB'(pick_frac()));
				write_cfg(REG_INIT_ENERGY, pick_energy());
			end
		end

		calm = 1'b0;
		in_valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.failures == 0 && sb.expected_words.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> battery_energy_tracker_hysteresis.f
+incdir+rtl
rtl/bet_pkg.sv
rtl/bet_ctrl.sv
rtl/bet_dp.sv
rtl/battery_energy_tracker_hysteresis.sv
sim/battery_energy_tracker_hysteresis_tb.sv
